### hdl/sfr_pkg.sv
// shared types, constants and helpers for the stream find-and-replace unit
`default_nettype none
package sfr_pkg;

  localparam int MAX_NEEDLE  = 8;
  localparam int MAX_REPL    = 8;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int WIN_IDX_W   = 3;
  localparam int BURST_BYTES = 8;
  localparam int BURST_W     = BURST_BYTES * BYTE_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_BYTES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN     = 2'd3;

  // effective configuration as seen by the front end
  typedef struct packed {
    logic [BURST_W-1:0] needle;
    logic [LEN_W-1:0]   nlen;
    logic [BURST_W-1:0] repl;
    logic [LEN_W-1:0]   rlen;
  } cfg_t;

  // one burst of result bytes caused by one input transaction
  typedef struct packed {
    logic [BURST_W-1:0] bytes;
    logic [LEN_W-1:0]   cnt;
    logic               last;
  } desc_t;

  // needle length, zero acts as one, clamped to the window size
  function automatic logic [LEN_W-1:0] eff_nlen(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (n == '0) r = LEN_W'(1);
    if (n > LEN_W'(MAX_NEEDLE)) r = LEN_W'(MAX_NEEDLE);
    return r;
  endfunction

  // replacement length clamped to the burst size
  function automatic logic [LEN_W-1:0] eff_rlen(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (n > LEN_W'(MAX_REPL)) r = LEN_W'(MAX_REPL);
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/sfr_front.sv
// front end: pending window, needle compare and burst classification
`default_nettype none
module sfr_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sfr_pkg::cfg_t               cfg,
  input  wire logic                        clr,
  input  wire logic                        in_accept,
  input  wire logic [sfr_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                        in_last,
  output logic                             push,
  output sfr_pkg::desc_t                   desc
);

  logic [sfr_pkg::BYTE_W-1:0]  win_r   [sfr_pkg::MAX_NEEDLE];
  logic [sfr_pkg::BYTE_W-1:0]  win_nxt [sfr_pkg::MAX_NEEDLE];
  logic [sfr_pkg::BYTE_W-1:0]  win_app [sfr_pkg::MAX_NEEDLE];
  logic [sfr_pkg::LEN_W-1:0]   cnt_r, cnt_nxt, cnt_app;
  logic [sfr_pkg::BURST_W-1:0] app_flat;
  logic [sfr_pkg::MAX_NEEDLE-1:0] eq;
  logic                        full, match;

  // append the new byte and compare the window against the needle
  always_comb begin
    for (int i = 0; i < sfr_pkg::MAX_NEEDLE; i++) begin
      win_app[i] = (cnt_r == sfr_pkg::LEN_W'(i)) ? in_byte : win_r[i];
      app_flat[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = win_app[i];
      eq[i] = (win_app[i] == cfg.needle[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]) ||
              (sfr_pkg::LEN_W'(i) >= cfg.nlen);
    end
    cnt_app = cnt_r + sfr_pkg::LEN_W'(1);
    full    = (cnt_app >= cfg.nlen);
    match   = full && (&eq);
  end

  // classify: replacement, flush, oldest byte out, or keep filling
  always_comb begin
    desc.bytes = '0;
    desc.cnt   = '0;
    desc.last  = in_last;
    cnt_nxt    = cnt_app;
    win_nxt    = win_app;
    if (match) begin
      desc.bytes = cfg.repl;
      desc.cnt   = cfg.rlen;
      cnt_nxt    = '0;
    end else if (in_last) begin
      desc.bytes = app_flat;
      desc.cnt   = cnt_app;
      cnt_nxt    = '0;
    end else if (full) begin
      desc.bytes = sfr_pkg::BURST_W'(win_app[0]);
      desc.cnt   = sfr_pkg::LEN_W'(1);
      cnt_nxt    = cnt_app - sfr_pkg::LEN_W'(1);
      for (int i = 0; i < sfr_pkg::MAX_NEEDLE - 1; i++) begin
        win_nxt[i] = win_app[i+1];
      end
    end
    push = in_accept && ((desc.cnt != '0) || in_last);
  end

  // pending count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (clr) begin
      cnt_r <= '0;
    end else if (in_accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (in_accept) begin
      win_r <= win_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/sfr_queue.sv
// two-entry burst queue between front and back end
`default_nettype none
module sfr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sfr_pkg::desc_t push_desc,
  input  wire logic           pop,
  output sfr_pkg::desc_t      head,
  output logic                empty,
  output logic                full
);

  sfr_pkg::desc_t q_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;

  assign head  = q_r[rd_ptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule
`default_nettype wire

### hdl/sfr_back.sv
// back end: serializes bursts into output bytes through an output register
`default_nettype none
module sfr_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sfr_pkg::desc_t             head,
  input  wire logic                       empty,
  output logic                            pop,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [sfr_pkg::BYTE_W-1:0]      out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);

  logic [sfr_pkg::WIN_IDX_W-1:0] idx_r, idx_nxt;
  logic                          vld_r;
  logic [sfr_pkg::BYTE_W-1:0]    data_r, data_nxt;
  logic                          user_r, user_nxt, last_r, last_nxt;
  logic                          load, final_byte, marker;

  // pick the next byte of the head burst
  always_comb begin
    load       = !empty && (!vld_r || out_tready);
    marker     = (head.cnt == '0);
    final_byte = marker ||
                 ({1'b0, idx_r} == head.cnt - sfr_pkg::LEN_W'(1));
    data_nxt   = marker ? '0 :
                 sfr_pkg::BYTE_W'(head.bytes >> {idx_r, 3'b000});
    user_nxt   = !marker;
    last_nxt   = head.last && final_byte;
    pop        = load && final_byte;
    idx_nxt    = idx_r;
    if (load) begin
      idx_nxt = final_byte ? '0 : idx_r + sfr_pkg::WIN_IDX_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

### hdl/stream_find_and_replace_unit.sv
// top level of the stream find-and-replace unit with its register file
// result path: an accepted byte's burst is written into the queue, then loaded into the output
//   register, which drives out_tvalid
// throughput: one input byte per cycle while each byte yields at most one result and out_tready
//   holds; a burst is sent byte by byte, input stalls once both queue entries are taken
// reset: synchronous active low; clears window count, queue, output valid; needle_length 1, rest 0
`default_nettype none
module stream_find_and_replace_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] in_byte
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [7:0]                            out_tdata,  // [7:0] out_byte
  output logic                                  out_tuser,  // [0] out_valid
  output logic                                  out_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [sfr_pkg::BURST_W-1:0] needle_r, repl_r;
  logic [sfr_pkg::LEN_W-1:0]   nlen_r, rlen_r;
  sfr_pkg::cfg_t               cfg;
  sfr_pkg::desc_t              push_desc, head;
  logic                        clr, in_accept, push, pop, q_empty, q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r <= '0;
      nlen_r   <= sfr_pkg::LEN_W'(1);
      repl_r   <= '0;
      rlen_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::REG_NEEDLE_BYTES: needle_r <= cfg_data;
        sfr_pkg::REG_NEEDLE_LEN:   nlen_r   <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPL_BYTES:   repl_r   <= cfg_data;
        sfr_pkg::REG_REPL_LEN:     rlen_r   <= cfg_data[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective configuration and handshake
  always_comb begin
    cfg.needle = needle_r;
    cfg.nlen   = sfr_pkg::eff_nlen(nlen_r);
    cfg.repl   = repl_r;
    cfg.rlen   = sfr_pkg::eff_rlen(rlen_r);
  end

  assign clr       = cfg_we && (cfg_index == sfr_pkg::REG_NEEDLE_LEN);
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .clr       (clr),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .push      (push),
    .desc      (push_desc)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### hdl/sfr_checker.sv
// port-level checker for the stream find-and-replace unit, bound to the top level
`default_nettype none
module sfr_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,
  input  wire logic       out_tuser,
  input  wire logic       out_tlast
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("output changed while stalled");

  // a bare end marker carries no byte and closes the text
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == 8'h00))
    else $error("bad end marker");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // no result in the first cycle after reset releases
  a_no_early: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_tvalid)
    else $error("result right after reset");

endmodule

bind stream_find_and_replace_unit sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

### sim/tb_stream_find_and_replace_unit.sv
// testbench for the stream find-and-replace unit: directed and random texts checked byte by byte
module tb_stream_find_and_replace_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  // one output transaction: byte, data flag, end of text
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } out_beat_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = '0;
  logic                           in_tlast   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  logic                           cfg_we     = 1'b0;
  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  // shadow of the register file and of the match window
  logic [63:0] needle_bytes_r;
  logic [3:0]  needle_len_r;
  logic [63:0] repl_bytes_r;
  logic [3:0]  repl_len_r;
  logic [7:0]  held_bytes [sfr_pkg::MAX_NEEDLE];
  int unsigned held_count;

  out_beat_t   due_output[$];
  logic [7:0]  source_text[$];
  int          mismatch_count = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles   = 0;

  always #HALF_PERIOD clk = ~clk;

  stream_find_and_replace_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // register write as the block sees it; a new needle length drops the window
  function automatic void apply_register(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [63:0] value);
    case (idx)
      sfr_pkg::REG_NEEDLE_BYTES: needle_bytes_r = value;
      sfr_pkg::REG_NEEDLE_LEN: begin
        needle_len_r = value[3:0];
        held_count   = 0;
      end
      sfr_pkg::REG_REPL_BYTES: repl_bytes_r = value;
      sfr_pkg::REG_REPL_LEN: repl_len_r = value[3:0];
      default: ;
    endcase
  endfunction

  // output bytes caused by one source byte, queued in order
  function automatic void replace_step(input logic [7:0] b, input logic last);
    out_beat_t   burst [8];
    int unsigned n, r, k, i;
    bit          hit;
    n = (needle_len_r == 4'd0) ? 1 :
        ((needle_len_r > sfr_pkg::MAX_NEEDLE) ? sfr_pkg::MAX_NEEDLE : needle_len_r);
    r = (repl_len_r > sfr_pkg::MAX_REPL) ? sfr_pkg::MAX_REPL : repl_len_r;
    k = 0;
    if (held_count < sfr_pkg::MAX_NEEDLE) begin
      held_bytes[held_count] = b;
      held_count++;
    end
    // full window: replace on a match, else release the oldest byte
    if (held_count >= n) begin
      hit = 1'b1;
      for (i = 0; i < n; i++)
        if (held_bytes[i] != needle_bytes_r[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < r; i++) begin
          burst[k] = {repl_bytes_r[8*i +: 8], 1'b1, 1'b0};
          k++;
        end
        held_count = 0;
      end else begin
        burst[k] = {held_bytes[0], 1'b1, 1'b0};
        k++;
        for (i = 1; i < held_count; i++) held_bytes[i-1] = held_bytes[i];
        held_count--;
      end
    end
    // end of text: flush, or send a bare marker when nothing came out
    if (last) begin
      for (i = 0; i < held_count && k < 8; i++) begin
        burst[k] = {held_bytes[i], 1'b1, 1'b0};
        k++;
      end
      held_count = 0;
      if (k == 0) begin
        burst[k] = {8'h00, 1'b0, 1'b0};
        k++;
      end
      burst[k-1].last = 1'b1;
    end
    for (i = 0; i < k; i++) due_output.push_back(burst[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // receiver stalls at random
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each output transaction with the oldest queued byte
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_output.size() == 0) begin
        report_mismatch("unexpected transaction", 8'h00, out_tdata);
      end else begin
        want = due_output.pop_front();
        if (out_tdata !== want.data) report_mismatch("out_byte", want.data, out_tdata);
        if (out_tuser !== want.valid)
          report_mismatch("out_valid", {7'd0, want.valid}, {7'd0, out_tuser});
        if (out_tlast !== want.last)
          report_mismatch("out_last", {7'd0, want.last}, {7'd0, out_tlast});
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL stream_find_and_replace_unit");
      $finish;
    end
  end

  // stop sending and let every queued byte come out
  task automatic drain_output();
    in_tvalid = 1'b0;
    while (due_output.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [63:0] value);
    drain_output();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    apply_register(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [63:0] nb, input logic [63:0] nl,
                            input logic [63:0] rb, input logic [63:0] rl);
    write_register(sfr_pkg::REG_NEEDLE_BYTES, nb);
    write_register(sfr_pkg::REG_NEEDLE_LEN, nl);
    write_register(sfr_pkg::REG_REPL_BYTES, rb);
    write_register(sfr_pkg::REG_REPL_LEN, rl);
  endtask

  // one source byte, with random gaps before it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    replace_step(b, last);
    @(negedge clk);
  endtask

  // reset settings delete zero bytes, so a lone zero ends in a bare marker
  task automatic test_end_marker();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // needle "aa" in "aaab": only the first pair is replaced
  task automatic test_non_overlap();
    set_config(64'h6161, 64'd2, 64'h5A5958, 64'd3);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
  endtask

  // longest needle: a match with oversized replacement length, then a full flush
  task automatic test_full_bursts();
    logic [63:0] needle;
    int          i;
    needle = 64'hFF00_8040_2010_0801;
    set_config(needle, 64'd8, 64'h1122_3344_5566_7788, 64'hFFFF_FFFF_FFFF_FFFF);
    for (i = 0; i < 8; i++) send_byte(needle[8*i +: 8], i == 7);
    write_register(sfr_pkg::REG_NEEDLE_LEN, 64'hF);
    needle[7:0] = ~needle[7:0];
    for (i = 0; i < 8; i++) send_byte(needle[8*i +: 8], i == 7);
  endtask

  // rewriting the needle length drops held bytes; zero length acts as one
  task automatic test_length_rewrite();
    set_config(64'h636261, 64'd3, 64'h2A, 64'd1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    write_register(sfr_pkg::REG_NEEDLE_LEN, 64'd0);
    send_byte(8'h61, 1'b1);
  endtask

  // random settings and texts built mostly from needle pieces
  task automatic test_random_texts(input int budget);
    int          sent, text_len, nlen_eff, piece, i, j;
    bit          noise;
    logic [7:0]  sym_a, sym_b;
    logic [63:0] nb;
    logic [3:0]  nl, rl;
    sent = 0;
    while (sent < budget) begin
      sym_a = 8'($urandom);
      sym_b = 8'($urandom);
      for (i = 0; i < 8; i++) nb[8*i +: 8] = $urandom_range(1) ? sym_a : sym_b;
      nl = ($urandom_range(9) < 7) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(0, 15));
      rl = ($urandom_range(9) < 8) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      set_config(nb, {$urandom, 28'($urandom), nl}, {$urandom, $urandom},
                 {$urandom, 28'($urandom), rl});
      nlen_eff = (nl == 4'd0) ? 1 : ((nl > sfr_pkg::MAX_NEEDLE) ? sfr_pkg::MAX_NEEDLE : nl);

      // build the text
      source_text.delete();
      text_len = $urandom_range(1, 14);
      noise = ($urandom_range(9) == 0);
      while (source_text.size() < text_len) begin
        if (noise) begin
          source_text.push_back(8'($urandom));
        end else begin
          case ($urandom_range(9))
            0, 1, 2, 3: begin
              for (j = 0; j < nlen_eff; j++) source_text.push_back(nb[8*j +: 8]);
            end
            4: begin
              piece = $urandom_range(1, nlen_eff);
              for (j = 0; j < piece; j++) source_text.push_back(nb[8*j +: 8]);
            end
            9: source_text.push_back(8'($urandom));
            default: source_text.push_back($urandom_range(1) ? sym_a : sym_b);
          endcase
        end
      end

      // send it, sometimes changing a register halfway
      for (i = 0; i < source_text.size(); i++) begin
        if (i == source_text.size() / 2 && i > 0 && $urandom_range(9) == 0) begin
          if ($urandom_range(1))
            write_register(sfr_pkg::REG_NEEDLE_LEN, 64'($urandom_range(0, 15)));
          else write_register(sfr_pkg::REG_REPL_BYTES, {$urandom, $urandom});
        end
        send_byte(source_text[i], i == source_text.size() - 1);
      end
      sent += source_text.size();
    end
  endtask

  initial begin
    int i;
    needle_bytes_r = '0;
    needle_len_r   = 4'd1;
    repl_bytes_r   = '0;
    repl_len_r     = 4'd0;
    held_count     = 0;
    for (i = 0; i < sfr_pkg::MAX_NEEDLE; i++) held_bytes[i] = 8'h00;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    send_gap_pct   = 8;
    recv_stall_pct = 81;
    test_end_marker();
    test_non_overlap();
    test_full_bursts();
    test_length_rewrite();
    test_random_texts(32);

    send_gap_pct   = 81;
    recv_stall_pct = 8;
    test_random_texts(32);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_texts(32);

    drain_output();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS stream_find_and_replace_unit");
    end else begin
      $display("FAIL stream_find_and_replace_unit");
    end
    $finish;
  end

endmodule
